// ----- hdl/cprn_pkg.sv -----
// cprn_pkg: shared types and codes for the cp model residual norm block
// no dependencies; used by the controller, the datapath and the top level
package cprn_pkg;

  // action codes of an input word
  localparam logic [2:0] ACT_WEIGHT  = 3'd0;
  localparam logic [2:0] ACT_FIRST   = 3'd1;
  localparam logic [2:0] ACT_SECOND  = 3'd2;
  localparam logic [2:0] ACT_THIRD   = 3'd3;
  localparam logic [2:0] ACT_TENSOR  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SIZE_SECOND = 2'd1;
  localparam logic [1:0] CFG_SIZE_THIRD  = 2'd2;
  localparam logic [1:0] CFG_RANK        = 2'd3;

  localparam int unsigned SQRT_STEPS = 32;

  typedef enum logic [1:0] {
    MUL_WA = 2'd0,
    MUL_TB = 2'd1,
    MUL_TC = 2'd2,
    MUL_SQ = 2'd3
  } mul_op_e;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RD   = 10'b0000000010,
    ST_M1   = 10'b0000000100,
    ST_M2   = 10'b0000001000,
    ST_M3   = 10'b0000010000,
    ST_ACC  = 10'b0000100000,
    ST_RES  = 10'b0001000000,
    ST_SQ   = 10'b0010000000,
    ST_SQRT = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic    load;
    logic    elem_start;
    logic    rd;
    logic    mul_en;
    mul_op_e mul_op;
    logic    acc;
    logic    sq_upd;
    logic    sqrt_step;
  } cmd_t;

  typedef struct packed {
    logic comp_last;
    logic elem_last;
    logic sqrt_last;
  } sts_t;

endpackage

// ----- hdl/cprn_ram.sv -----
// cprn_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module cprn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/cprn_ctrl.sv -----
// cprn_ctrl: sequencer for loads, per-component multiply passes and the square root
// depends on cprn_pkg
module cprn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [2:0]      action_i,
  input  cprn_pkg::sts_t  sts_i,
  output cprn_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            done_o
);

  cprn_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cprn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_op = cprn_pkg::MUL_WA;
    unique case (state_q)
      cprn_pkg::ST_IDLE: begin
        if (start) begin
          if (action_i == cprn_pkg::ACT_TENSOR) begin
            cmd_o.elem_start = 1'b1;
            state_d = cprn_pkg::ST_RD;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      cprn_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d = cprn_pkg::ST_M1;
      end
      cprn_pkg::ST_M1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = cprn_pkg::MUL_WA;
        state_d = cprn_pkg::ST_M2;
      end
      cprn_pkg::ST_M2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = cprn_pkg::MUL_TB;
        state_d = cprn_pkg::ST_M3;
      end
      cprn_pkg::ST_M3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = cprn_pkg::MUL_TC;
        state_d = cprn_pkg::ST_ACC;
      end
      cprn_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = sts_i.comp_last ? cprn_pkg::ST_RES : cprn_pkg::ST_RD;
      end
      cprn_pkg::ST_RES: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = cprn_pkg::MUL_SQ;
        state_d = cprn_pkg::ST_SQ;
      end
      cprn_pkg::ST_SQ: begin
        cmd_o.sq_upd = 1'b1;
        state_d = sts_i.elem_last ? cprn_pkg::ST_SQRT : cprn_pkg::ST_IDLE;
      end
      cprn_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = cprn_pkg::ST_DONE;
        end
      end
      cprn_pkg::ST_DONE: begin
        state_d = cprn_pkg::ST_IDLE;
      end
      default: begin
        state_d = cprn_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != cprn_pkg::ST_IDLE);
  assign done_o = (state_q == cprn_pkg::ST_DONE);

endmodule

// ----- hdl/cprn_dp.sv -----
// cprn_dp: stores, shared multiplier, accumulators, counters and bit-pair square root
// depends on cprn_pkg and cprn_ram
module cprn_dp #(
  parameter int MAX_DIM   = 64,
  parameter int MAX_RANK  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cprn_pkg::cmd_t        cmd_i,
  output cprn_pkg::sts_t        sts_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [6:0]            cfg_data_i,
  input  logic [2:0]            action_i,
  input  logic [5:0]            row_index_i,
  input  logic [3:0]            component_i,
  input  logic signed [31:0]    value_i,
  output logic [31:0]           error_norm_o,
  output logic                  saturated_o
);

  localparam int DW    = $clog2(MAX_DIM);
  localparam int SW    = DW + 1;
  localparam int LW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int DEPTH = MAX_DIM * MAX_RANK;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = 33 + $clog2(MAX_RANK);
  localparam int PW    = 66;
  localparam int XW    = 72;

  function automatic logic [31:0] clamp_reg(input logic [31:0] v, input int hi);
    logic [31:0] r;
    r = v;
    if (v == 32'd0) r = 32'd1;
    else if (v > 32'(hi)) r = 32'(hi);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > XW'(signed'(32'h7fffffff))) r = 32'h7fffffff;
    else if (v < XW'(signed'(32'h80000000))) r = 32'h80000000;
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [XW-1:0] v);
    return (v > XW'(signed'(32'h7fffffff))) || (v < XW'(signed'(32'h80000000)));
  endfunction

  // configuration
  logic [6:0] size1_q, size2_q, size3_q;
  logic [4:0] rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size1_q <= 7'd1;
      size2_q <= 7'd1;
      size3_q <= 7'd1;
      rank_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cprn_pkg::CFG_SIZE_FIRST:  size1_q <= cfg_data_i;
        cprn_pkg::CFG_SIZE_SECOND: size2_q <= cfg_data_i;
        cprn_pkg::CFG_SIZE_THIRD:  size3_q <= cfg_data_i;
        cprn_pkg::CFG_RANK:        rank_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] s1, s2, s3;
  logic [31:0]   rk;
  assign s1 = SW'(clamp_reg(32'(size1_q), MAX_DIM));
  assign s2 = SW'(clamp_reg(32'(size2_q), MAX_DIM));
  assign s3 = SW'(clamp_reg(32'(size3_q), MAX_DIM));
  assign rk = clamp_reg(32'(rank_q), MAX_RANK);

  // stores
  logic        row_ok, comp_ok;
  logic [AW-1:0] ld_addr;
  logic [31:0] w_rd, a_rd, b_rd, c_rd;
  logic [DW-1:0] pf_q, ps_q, pt_q, pf_d, ps_d, pt_d;
  logic [LW-1:0] l_q;

  assign row_ok  = 32'(row_index_i) < 32'(MAX_DIM);
  assign comp_ok = 32'(component_i) < 32'(MAX_RANK);
  assign ld_addr = AW'(32'(row_index_i) * MAX_RANK + 32'(component_i));

  cprn_ram #(.WIDTH(32), .DEPTH(MAX_RANK)) u_weight (
    .clk_i, .we_i(cmd_i.load && action_i == cprn_pkg::ACT_WEIGHT && comp_ok),
    .waddr_i(LW'(component_i)), .wdata_i(value_i),
    .re_i(cmd_i.rd), .raddr_i(l_q), .rdata_o(w_rd)
  );

  cprn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_first (
    .clk_i, .we_i(cmd_i.load && action_i == cprn_pkg::ACT_FIRST && row_ok && comp_ok),
    .waddr_i(ld_addr), .wdata_i(value_i),
    .re_i(cmd_i.rd), .raddr_i(AW'(32'(pf_q) * MAX_RANK + 32'(l_q))), .rdata_o(a_rd)
  );

  cprn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_second (
    .clk_i, .we_i(cmd_i.load && action_i == cprn_pkg::ACT_SECOND && row_ok && comp_ok),
    .waddr_i(ld_addr), .wdata_i(value_i),
    .re_i(cmd_i.rd), .raddr_i(AW'(32'(ps_q) * MAX_RANK + 32'(l_q))), .rdata_o(b_rd)
  );

  cprn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_third (
    .clk_i, .we_i(cmd_i.load && action_i == cprn_pkg::ACT_THIRD && row_ok && comp_ok),
    .waddr_i(ld_addr), .wdata_i(value_i),
    .re_i(cmd_i.rd), .raddr_i(AW'(32'(pt_q) * MAX_RANK + 32'(l_q))), .rdata_o(c_rd)
  );

  // shared multiplier
  logic signed [PW-1:0] prod_q, prod_d, prod_sh;
  logic signed [32:0]   mul_a, mul_b;
  logic signed [31:0]   t_sat, resid;
  logic                 t_ovf, r_ovf;
  logic signed [MW-1:0] model_q;
  logic signed [MW:0]   resid_full;
  logic signed [31:0]   x_q;
  logic signed [32:0]   resid_neg;
  logic [31:0]          mag;

  assign prod_sh    = prod_q >>> FRAC_BITS;
  assign t_sat      = sat32(XW'(prod_sh));
  assign t_ovf      = ovf32(XW'(prod_sh));
  assign resid_full = (MW + 1)'(model_q) - (MW + 1)'(x_q);
  assign resid      = sat32(XW'(resid_full));
  assign r_ovf      = ovf32(XW'(resid_full));
  assign resid_neg  = -(33'(resid));
  assign mag        = resid[31] ? resid_neg[31:0] : resid[31:0];

  always_comb begin
    case (cmd_i.mul_op)
      cprn_pkg::MUL_WA: begin
        mul_a = 33'(signed'(w_rd));
        mul_b = 33'(signed'(a_rd));
      end
      cprn_pkg::MUL_TB: begin
        mul_a = 33'(t_sat);
        mul_b = 33'(signed'(b_rd));
      end
      cprn_pkg::MUL_TC: begin
        mul_a = 33'(t_sat);
        mul_b = 33'(signed'(c_rd));
      end
      default: begin
        mul_a = signed'({1'b0, mag});
        mul_b = signed'({1'b0, mag});
      end
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.elem_start) begin
      x_q <= value_i;
    end
  end

  // component loop and model sum
  assign sts_o.comp_last = (32'(l_q) + 32'd1) >= rk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q     <= '0;
      model_q <= '0;
    end else if (cmd_i.elem_start) begin
      l_q     <= '0;
      model_q <= '0;
    end else if (cmd_i.acc) begin
      l_q     <= l_q + LW'(1);
      model_q <= model_q + MW'(t_sat);
    end
  end

  // square sum, flag and element position
  logic [63:0] sum_q, sum_d, sum_new;
  logic [64:0] sum_ext;
  logic        sum_ovf, flag_q, flag_d, sat_out_q, sat_out_d;
  logic        wrap1, wrap2, wrap3;

  assign sum_ext = {1'b0, sum_q} + {1'b0, prod_q[63:0]};
  assign sum_ovf = sum_ext[64];
  assign sum_new = sum_ovf ? '1 : sum_ext[63:0];

  assign wrap1 = (SW'(pf_q) + SW'(1)) >= s1;
  assign wrap2 = (SW'(ps_q) + SW'(1)) >= s2;
  assign wrap3 = (SW'(pt_q) + SW'(1)) >= s3;
  assign sts_o.elem_last = wrap1 && wrap2 && wrap3;

  always_comb begin
    flag_d    = flag_q;
    sat_out_d = sat_out_q;
    sum_d     = sum_q;
    pf_d      = pf_q;
    ps_d      = ps_q;
    pt_d      = pt_q;
    if (cmd_i.mul_en && (cmd_i.mul_op == cprn_pkg::MUL_TB ||
                         cmd_i.mul_op == cprn_pkg::MUL_TC)) begin
      flag_d = flag_d | t_ovf;
    end
    if (cmd_i.mul_en && cmd_i.mul_op == cprn_pkg::MUL_SQ) begin
      flag_d = flag_d | r_ovf;
    end
    if (cmd_i.acc) begin
      flag_d = flag_d | t_ovf;
    end
    if (cmd_i.sq_upd) begin
      flag_d = flag_d | sum_ovf;
      sum_d  = sum_new;
      if (sts_o.elem_last) begin
        sat_out_d = flag_d;
        flag_d    = 1'b0;
        sum_d     = '0;
        pf_d      = '0;
        ps_d      = '0;
        pt_d      = '0;
      end else if (!wrap1) begin
        pf_d = pf_q + DW'(1);
      end else begin
        pf_d = '0;
        if (!wrap2) begin
          ps_d = ps_q + DW'(1);
        end else begin
          ps_d = '0;
          pt_d = wrap3 ? '0 : pt_q + DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      flag_q    <= 1'b0;
      sat_out_q <= 1'b0;
      pf_q      <= '0;
      ps_q      <= '0;
      pt_q      <= '0;
    end else begin
      sum_q     <= sum_d;
      flag_q    <= flag_d;
      sat_out_q <= sat_out_d;
      pf_q      <= pf_d;
      ps_q      <= ps_d;
      pt_q      <= pt_d;
    end
  end

  // square root, two radicand bits per step
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  step_q;
  logic [35:0] rem_sh, trial;
  logic        take;

  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = rem_sh >= trial;
  assign sts_o.sqrt_last = (step_q == 5'(cprn_pkg::SQRT_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.sq_upd) begin
      step_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      step_q <= step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_upd && sts_o.elem_last) begin
      rad_q  <= sum_new;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_q <= {root_q[30:0], take};
    end
  end

  assign error_norm_o = root_q;
  assign saturated_o  = sat_out_q;

endmodule

// ----- hdl/cp_model_residual_norm.sv -----
// cp_model_residual_norm: top level, residual norm of a rank-L cp model of a 3-way tensor
// depends on cprn_pkg, cprn_ctrl, cprn_dp (and cprn_ram through the datapath)
//
// Weight, factor and tensor words are taken when start is high and busy is low. A load
// word is written to its store in that cycle and busy stays low. A tensor word sets busy
// for a store read, three chained Q16.16 products on one shared multiplier and a model
// accumulate per component in use, then for the residual square and the sum update. The
// last word of a tensor adds 32 square root steps and an output state, in which done_o
// strobes error_norm_o and saturated_o for exactly one clock; there is no back-pressure,
// so capture it then. Configuration writes take effect at once and belong between tensors.
module cp_model_residual_norm #(
  parameter int MAX_DIM   = 64,
  parameter int MAX_RANK  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic [5:0]         row_index_i,
  input  logic [3:0]         component_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  output logic               done_o,
  output logic [31:0]        error_norm_o,
  output logic               saturated_o
);

  cprn_pkg::cmd_t cmd;
  cprn_pkg::sts_t sts;

  cprn_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .action_i,
    .sts_i(sts), .cmd_o(cmd), .busy, .done_o
  );

  cprn_dp #(
    .MAX_DIM(MAX_DIM), .MAX_RANK(MAX_RANK), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .action_i, .row_index_i, .component_i, .value_i,
    .error_norm_o, .saturated_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside a busy phase");

  a_tensor_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == cprn_pkg::ACT_TENSOR) |=> busy)
    else $error("tensor word did not start a computation");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i != cprn_pkg::ACT_TENSOR) |=> !busy)
    else $error("load word made the block busy");

endmodule

// ----- tb/cprn_checker.sv -----
// cprn_checker: watches the word, configuration and result ports of cp_model_residual_norm,
// predicts each residual norm and compares it with what the block strobes out
// depends on cprn_pkg for the action and register codes
`timescale 1ns / 1ps

module cprn_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         action_i,
  input  logic [5:0]         row_index_i,
  input  logic [3:0]         component_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               done_i,
  input  logic [31:0]        error_norm_i,
  input  logic               saturated_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  localparam int DIM       = 64;
  localparam int RANK      = 16;
  localparam int FRAC      = 16;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] norm;
    logic        sat;
  } norm_t;

  logic signed [31:0] weight_mem [RANK];
  logic signed [31:0] fac_a_mem  [DIM*RANK];
  logic signed [31:0] fac_b_mem  [DIM*RANK];
  logic signed [31:0] fac_c_mem  [DIM*RANK];
  logic [6:0]  size_i_q, size_j_q, size_k_q;
  logic [4:0]  rank_q;
  int unsigned pos_i, pos_j, pos_k;
  logic [63:0] sq_sum;
  logic        sat_seen;
  norm_t       norm_q [$];

  assign pending_o = norm_q.size();

  function automatic logic signed [31:0] clip32(input longint v, inout logic flag);
    if (v > S32_MAX) begin
      flag = 1'b1;
      return S32_MAX[31:0];
    end
    if (v < S32_MIN) begin
      flag = 1'b1;
      return S32_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // arithmetic shift of the exact product floors toward minus infinity
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              inout logic flag);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> FRAC, flag);
  endfunction

  function automatic int unsigned clampv(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] root64(input logic [63:0] n);
    logic [63:0] res, one_v;
    res   = '0;
    one_v = 64'd1 << 62;
    while (one_v > n) one_v = one_v >> 2;
    while (one_v != 0) begin
      if (n >= res + one_v) begin
        n   = n - (res + one_v);
        res = (res >> 1) + one_v;
      end else begin
        res = res >> 1;
      end
      one_v = one_v >> 2;
    end
    return res[31:0];
  endfunction

  task automatic add_element(input logic signed [31:0] x);
    int unsigned s1, s2, s3, rk, ri, rj, rl;
    longint      model;
    logic signed [31:0] t, resid;
    logic [63:0] mag, sq;
    logic        flag;
    flag  = sat_seen;
    s1    = clampv(size_i_q, DIM);
    s2    = clampv(size_j_q, DIM);
    s3    = clampv(size_k_q, DIM);
    rk    = clampv(rank_q, RANK);
    ri    = pos_i % DIM;
    rj    = pos_j % DIM;
    rl    = pos_k % DIM;
    model = 0;
    for (int l = 0; l < rk; l++) begin
      t = qmul(weight_mem[l], fac_a_mem[ri*RANK+l], flag);
      t = qmul(t, fac_b_mem[rj*RANK+l], flag);
      t = qmul(t, fac_c_mem[rl*RANK+l], flag);
      model += longint'(t);
    end
    resid = clip32(model - longint'(x), flag);
    mag   = resid < 0 ? 64'(-longint'(resid)) : 64'(longint'(resid));
    sq    = mag * mag;
    if (sq_sum > ~64'd0 - sq) begin
      sq_sum = ~64'd0;
      flag   = 1'b1;
    end else begin
      sq_sum = sq_sum + sq;
    end
    sat_seen = flag;
    if (pos_i + 1 >= s1 && pos_j + 1 >= s2 && pos_k + 1 >= s3) begin
      norm_q.push_back('{norm: root64(sq_sum), sat: sat_seen});
      pos_i    = 0;
      pos_j    = 0;
      pos_k    = 0;
      sq_sum   = '0;
      sat_seen = 1'b0;
    end else begin
      pos_i++;
      if (pos_i >= s1) begin
        pos_i = 0;
        pos_j++;
        if (pos_j >= s2) begin
          pos_j = 0;
          pos_k++;
          if (pos_k >= s3) pos_k = 0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    norm_t exp_w;
    if (!rst_ni) begin
      size_i_q   = 7'd1;
      size_j_q   = 7'd1;
      size_k_q   = 7'd1;
      rank_q     = 5'd1;
      pos_i      = 0;
      pos_j      = 0;
      pos_k      = 0;
      sq_sum     = '0;
      sat_seen   = 1'b0;
      fail_cnt_o = 0;
      norm_q.delete();
    end else begin
      if (done_i) begin
        if (norm_q.size() == 0) begin
          $error("result word with nothing expected: error_norm %h saturated %b",
                 error_norm_i, saturated_i);
          fail_cnt_o++;
        end else begin
          exp_w = norm_q.pop_front();
          if (error_norm_i !== exp_w.norm) begin
            $error("error_norm expected %h actual %h", exp_w.norm, error_norm_i);
            fail_cnt_o++;
          end
          if (saturated_i !== exp_w.sat) begin
            $error("saturated expected %b actual %b", exp_w.sat, saturated_i);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cprn_pkg::CFG_SIZE_FIRST:  size_i_q = cfg_data_i;
          cprn_pkg::CFG_SIZE_SECOND: size_j_q = cfg_data_i;
          cprn_pkg::CFG_SIZE_THIRD:  size_k_q = cfg_data_i;
          cprn_pkg::CFG_RANK:        rank_q   = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        case (action_i)
          cprn_pkg::ACT_WEIGHT: weight_mem[component_i]                = value_i;
          cprn_pkg::ACT_FIRST:  fac_a_mem[row_index_i*RANK+component_i] = value_i;
          cprn_pkg::ACT_SECOND: fac_b_mem[row_index_i*RANK+component_i] = value_i;
          cprn_pkg::ACT_THIRD:  fac_c_mem[row_index_i*RANK+component_i] = value_i;
          cprn_pkg::ACT_TENSOR: add_element(value_i);
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/cp_model_residual_norm_test.sv -----
// cp_model_residual_norm_test: stimulus and verdict for cp_model_residual_norm
// depends on cprn_pkg, the block and cprn_checker, which predicts and compares
`timescale 1ns / 1ps

module cp_model_residual_norm_test;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         action_i;
  logic [5:0]         row_index_i;
  logic [3:0]         component_i;
  logic signed [31:0] value_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [6:0]         cfg_data_i;
  logic               done_o;
  logic [31:0]        error_norm_o;
  logic               saturated_o;
  int                 fail_cnt;
  int                 pending;
  int                 idle_pct;
  int                 quiet_cycles = 0;

  cp_model_residual_norm i_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .row_index_i, .component_i, .value_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .error_norm_o, .saturated_o
  );

  cprn_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .action_i, .row_index_i,
    .component_i, .value_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_i(done_o),
    .error_norm_i(error_norm_o), .saturated_i(saturated_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 4000) begin
      $display("cp_model_residual_norm verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3:    return $urandom;
      4, 5, 6: return $urandom_range(0, 262144) - 131072;
      default: return $urandom_range(0, 131072) - 65536;
    endcase
  endfunction

  task automatic send(input logic [2:0] act, input logic [5:0] row, input logic [3:0] comp,
                      input logic signed [31:0] val);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= act;
    row_index_i <= row;
    component_i <= comp;
    value_i     <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [6:0] s1, input logic [6:0] s2,
                            input logic [6:0] s3, input logic [6:0] rk);
    logic [6:0] vals [4];
    vals  = '{s1, s2, s3, rk};
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    // a partial tensor can still be in flight with nothing expected
    repeat (120) @(posedge clk_i);
    for (int r = 0; r < 4; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r[1:0];
      cfg_data_i <= vals[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int r;
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = cprn_pkg::ACT_WEIGHT;
    row_index_i  = '0;
    component_i  = '0;
    value_i      = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = cprn_pkg::CFG_SIZE_FIRST;
    cfg_data_i   = '0;
    idle_pct     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // component 0 of every row and all components of rows 0..3 are filled;
    // ranks above one are only used while every size is at most 3
    for (int c = 0; c < 16; c++) send(cprn_pkg::ACT_WEIGHT, 6'($urandom), c[3:0], pick_value());
    for (int f = 1; f <= 3; f++) begin
      for (int row = 0; row < 64; row++) begin
        for (int c = 0; c < 16; c++) begin
          if (c == 0 || row < 4) send(f[2:0], row[5:0], c[3:0], pick_value());
        end
      end
    end

    // zero model: residual saturates on the most negative element
    send(cprn_pkg::ACT_WEIGHT, 6'd0, 4'd0, 32'sd0);
    send(cprn_pkg::ACT_TENSOR, 6'd63, 4'd15, 32'sh80000000);
    send(cprn_pkg::ACT_TENSOR, 6'd0, 4'd0, 32'sh7FFFFFFF);
    send(cprn_pkg::ACT_TENSOR, 6'd0, 4'd0, 32'sd0);
    // five maximal squares overflow the sum
    set_config(7'd5, 7'd1, 7'd1, 7'd1);
    repeat (5) send(cprn_pkg::ACT_TENSOR, 6'd0, 4'd0, 32'sh80000000);
    set_config(7'd1, 7'd1, 7'd1, 7'd1);
    // product chain saturation, both signs
    send(cprn_pkg::ACT_WEIGHT, 6'd0, 4'd0, 32'sh7FFFFFFF);
    send(cprn_pkg::ACT_FIRST, 6'd0, 4'd0, 32'sh7FFFFFFF);
    send(cprn_pkg::ACT_SECOND, 6'd0, 4'd0, 32'sh7FFFFFFF);
    send(cprn_pkg::ACT_THIRD, 6'd0, 4'd0, 32'sh7FFFFFFF);
    send(cprn_pkg::ACT_TENSOR, 6'd0, 4'd0, 32'sh00010000);
    send(cprn_pkg::ACT_WEIGHT, 6'd0, 4'd0, 32'sh80000000);
    send(cprn_pkg::ACT_TENSOR, 6'd0, 4'd0, 32'sh7FFFFFFF);
    send(3'd5, 6'd63, 4'd15, 32'sh7FFFFFFF);
    send(3'd6, 6'd0, 4'd0, 32'sd0);
    send(3'd7, 6'd63, 4'd15, 32'sh80000000);
    send(cprn_pkg::ACT_WEIGHT, 6'd0, 4'd0, 32'sh00010000);

    for (int p = 0; p < 16; p++) begin
      int n_items;
      // large sizes run at rank one; the all-ones sizes after them close any partial tensor
      case (p)
        0:       set_config(7'd1, 7'd1, 7'd1, 7'd1);
        1:       set_config(7'd64, 7'd1, 7'd1, 7'd1);
        2:       set_config(7'd1, 7'd64, 7'd1, 7'd0);
        3:       set_config(7'd1, 7'd1, 7'd127, 7'd33);
        4:       set_config(7'd0, 7'd0, 7'd0, 7'd32);
        default: set_config(7'($urandom_range(0, 3)), 7'($urandom_range(1, 3)),
                            7'($urandom_range(1, 3)), 7'($urandom_range(0, 17)));
      endcase
      case (p % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 60;
        2:       idle_pct = 0;
        default: idle_pct = 32;
      endcase
      n_items = (p >= 1 && p <= 3) ? 120 : 60;
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(99);
        if (r < 62) begin
          send(cprn_pkg::ACT_TENSOR, 6'($urandom), 4'($urandom), pick_value());
        end else if (r < 94) begin
          send(3'($urandom_range(0, 3)), 6'($urandom), 4'($urandom), pick_value());
        end else begin
          send(3'($urandom_range(5, 7)), 6'($urandom), 4'($urandom), $urandom);
        end
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("cp_model_residual_norm verification clean");
    end else begin
      $display("cp_model_residual_norm verification failed");
    end
    $finish;
  end

endmodule
